### sv/smdb_pkg.sv
package smdb_pkg;

    localparam int COMP_W      = 16;
    localparam int MAG_W       = 16;
    localparam int BIN_W       = 12;
    localparam int DOM_W       = 11;
    localparam int FRAME_LEN_W = 13;
    localparam int SUM_W       = 32;

    localparam int MAX_BINS       = 4096;
    localparam int FRAME_LEN_MIN  = 2;
    localparam int FRAME_LEN_RST  = 1024;
    localparam int MAG_MAX        = 46340;

    localparam int ROOT_STEPS  = 16;
    localparam int STEP_W      = $clog2(ROOT_STEPS);
    localparam logic [SUM_W-1:0] ROOT_START = 32'h4000_0000;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [COMP_W-1:0] a;
        logic [COMP_W-1:0] b;
    } t_pair;

    typedef struct packed {
        logic  valid;
        t_pair data;
    } t_qhead;

    function automatic logic [COMP_W-1:0] abs_comp(input logic signed [COMP_W-1:0] v);
        logic [COMP_W-1:0] u;
        u = COMP_W'(v);
        if (u[COMP_W-1]) begin
            return COMP_W'(0) - u;
        end
        return u;
    endfunction

endpackage

### sv/smdb_channels.sv
interface smdb_bin_if;
    import smdb_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [COMP_W-1:0] real_part;
    logic signed [COMP_W-1:0] imag_part;
    modport source (output valid, output real_part, output imag_part, input ready);
    modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

interface smdb_res_if;
    import smdb_pkg::*;
    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude;
    logic [BIN_W-1:0] bin_index;
    logic             frame_done;
    logic [DOM_W-1:0] dominant_bin;
    logic [MAG_W-1:0] dominant_mag;
    modport source (output valid, output magnitude, output bin_index, output frame_done,
                    output dominant_bin, output dominant_mag, input ready);
    modport sink   (input valid, input magnitude, input bin_index, input frame_done,
                    input dominant_bin, input dominant_mag, output ready);
endinterface

interface smdb_cfg_if;
    import smdb_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [FRAME_LEN_W-1:0] frame_len;
    modport source (output valid, output frame_len, input ready);
    modport sink   (input valid, input frame_len, output ready);
endinterface

### sv/smdb_front.sv
module smdb_front #(
    parameter int QUEUE_DEPTH = smdb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    smdb_bin_if.sink        i_bin,
    input  logic            i_pop,
    output smdb_pkg::t_qhead o_head
);
    import smdb_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_pair          r_mem [QUEUE_DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           push;
    t_pair          word_in;

    // Magnitudes of the components are formed on entry, so the queue holds unsigned words.
    always_comb begin
        word_in.a = abs_comp(i_bin.real_part);
        word_in.b = abs_comp(i_bin.imag_part);
    end

    assign i_bin.ready  = (r_count != CW'(QUEUE_DEPTH));
    assign push         = i_bin.valid && i_bin.ready;
    assign o_head.valid = (r_count != '0);
    assign o_head.data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= word_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### sv/smdb_back.sv
module smdb_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [smdb_pkg::FRAME_LEN_W-1:0] i_frame_len,
    input  smdb_pkg::t_qhead                 i_head,
    output logic                             o_pop,
    smdb_res_if.source                       o_res
);
    import smdb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROOT = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]        r_state;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_acc;
    logic [SUM_W-1:0]  r_wt;

    logic [BIN_W-1:0]  r_bin_cnt;
    logic [MAG_W-1:0]  r_best_mag;
    logic [DOM_W-1:0]  r_best_bin;

    logic              r_out_valid;
    logic [MAG_W-1:0]  r_out_mag;
    logic [BIN_W-1:0]  r_out_bin;
    logic              r_out_done;
    logic [DOM_W-1:0]  r_out_dom_bin;
    logic [MAG_W-1:0]  r_out_dom_mag;

    logic [SUM_W-1:0]       sum_sq;
    logic [SUM_W-1:0]       trial;
    logic                   take;
    logic [SUM_W-1:0]       n_acc;
    logic [SUM_W-1:0]       n_rem;
    logic                   last_step;
    logic                   out_free;
    logic                   commit;
    logic [MAG_W-1:0]       mag;
    logic [FRAME_LEN_W-1:0] len_eff;
    logic [BIN_W-1:0]       half_len;
    logic                   upd;
    logic                   frame_last;
    logic [MAG_W-1:0]       n_best_mag;
    logic [DOM_W-1:0]       n_best_bin;

    assign sum_sq = SUM_W'(i_head.data.a) * SUM_W'(i_head.data.a)
                  + SUM_W'(i_head.data.b) * SUM_W'(i_head.data.b);

    // One restoring root step: the trial value is the partial root plus the current weight.
    always_comb begin
        trial = r_acc + r_wt;
        take  = (r_rem >= trial);
        n_acc = (r_acc >> 1) + (take ? r_wt : '0);
        n_rem = take ? (r_rem - trial) : r_rem;
    end

    assign last_step = (r_state == ST_ROOT) && (r_step == STEP_W'(ROOT_STEPS - 1));
    assign out_free  = !r_out_valid || o_res.ready;
    assign commit    = (last_step || (r_state == ST_HOLD)) && out_free;
    assign mag       = (r_state == ST_HOLD) ? r_acc[MAG_W-1:0] : n_acc[MAG_W-1:0];
    assign o_pop     = (r_state == ST_IDLE) && i_head.valid;

    always_comb begin
        if (i_frame_len < FRAME_LEN_W'(FRAME_LEN_MIN)) begin
            len_eff = FRAME_LEN_W'(FRAME_LEN_MIN);
        end else if (i_frame_len > FRAME_LEN_W'(MAX_BINS)) begin
            len_eff = FRAME_LEN_W'(MAX_BINS);
        end else begin
            len_eff = i_frame_len;
        end
        half_len   = len_eff[FRAME_LEN_W-1:1];
        upd        = (r_bin_cnt != '0) && (r_bin_cnt < half_len) && (mag > r_best_mag);
        n_best_mag = upd ? mag : r_best_mag;
        n_best_bin = upd ? r_bin_cnt[DOM_W-1:0] : r_best_bin;
        // A shortened length mid-frame ends the frame at the first bin at or past its end.
        frame_last = ({1'b0, r_bin_cnt} >= (len_eff - FRAME_LEN_W'(1)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_bin_cnt   <= '0;
            r_best_mag  <= '0;
            r_best_bin  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_head.valid) begin
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (last_step) begin
                        r_state <= commit ? ST_IDLE : ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (commit) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (commit) begin
                r_out_valid <= 1'b1;
                if (frame_last) begin
                    r_bin_cnt  <= '0;
                    r_best_mag <= '0;
                    r_best_bin <= '0;
                end else begin
                    r_bin_cnt  <= r_bin_cnt + 1'b1;
                    r_best_mag <= n_best_mag;
                    r_best_bin <= n_best_bin;
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem  <= sum_sq;
            r_acc  <= '0;
            r_wt   <= ROOT_START;
            r_step <= '0;
        end else if (r_state == ST_ROOT) begin
            r_rem  <= n_rem;
            r_acc  <= n_acc;
            r_wt   <= r_wt >> 2;
            r_step <= r_step + 1'b1;
        end
        if (commit) begin
            r_out_mag     <= mag;
            r_out_bin     <= r_bin_cnt;
            r_out_done    <= frame_last;
            r_out_dom_bin <= frame_last ? n_best_bin : '0;
            r_out_dom_mag <= frame_last ? n_best_mag : '0;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.magnitude    = r_out_mag;
    assign o_res.bin_index    = r_out_bin;
    assign o_res.frame_done   = r_out_done;
    assign o_res.dominant_bin = r_out_dom_bin;
    assign o_res.dominant_mag = r_out_dom_mag;

endmodule

### sv/spectrum_magnitude_dominant_bin.sv
// Spectrum magnitude and dominant bin. Each input word is one complex bin; each gives one
// result word with its magnitude, the floor square root of re*re + im*im, and its position
// in the frame. The last word of a frame also carries the largest magnitude seen over bins
// 1 to frame_len/2-1 and that bin's index, both zero when none exceeds zero. The square
// root unit is shared and sets the rate: it takes one bin at a time, forms the sum of
// squares, runs sixteen restoring root steps, and takes no new bin until the result is
// committed. A small queue ahead of the root unit takes up to QUEUE_DEPTH words while
// it is busy, and a result waits in an output register without halting the next root.
// frame_len is clamped to 2..4096 and should only be written while the block is idle.
module spectrum_magnitude_dominant_bin #(
    parameter int QUEUE_DEPTH = smdb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smdb_cfg_if.sink   i_cfg,
    smdb_bin_if.sink   i_bin,
    smdb_res_if.source o_res
);
    import smdb_pkg::*;

    logic [FRAME_LEN_W-1:0] r_frame_len;
    t_qhead                 head;
    logic                   pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= FRAME_LEN_W'(FRAME_LEN_RST);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_frame_len <= i_cfg.frame_len;
        end
    end

    smdb_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bin   (i_bin),
        .i_pop   (pop),
        .o_head  (head)
    );

    smdb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame_len (r_frame_len),
        .i_head      (head),
        .o_pop       (pop),
        .o_res       (o_res)
    );

    // Dominant fields are only reported on the word that closes a frame.
    a_dom_zero_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.frame_done |-> (o_res.dominant_bin == '0) &&
                                             (o_res.dominant_mag == '0))
        else $error("dominant fields set on a word that does not end a frame");

    // Bin zero is never tracked, so a zero dominant bin means nothing was kept.
    a_dom_bin_zero_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.frame_done && (o_res.dominant_bin == '0)
            |-> (o_res.dominant_mag == '0))
        else $error("dominant magnitude non-zero with dominant bin zero");

    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.magnitude <= MAG_W'(MAG_MAX)) &&
                        (o_res.dominant_mag <= MAG_W'(MAG_MAX)))
        else $error("magnitude beyond the largest possible root");

endmodule
